// ===== rtl/mdc_pkg.sv =====
// Shared types, register offsets and helper functions for the DMA controller core.
// No dependencies; used by the core and its checker.
package mdc_pkg;

	localparam int CHAN_STRIDE = 20;

	localparam logic [9:0] OFF_ISR   = 10'h000;
	localparam logic [9:0] OFF_IFCR  = 10'h004;
	localparam logic [9:0] OFF_CCR   = 10'h008;
	localparam logic [9:0] OFF_CNDTR = 10'h00c;
	localparam logic [9:0] OFF_CPAR  = 10'h010;
	localparam logic [9:0] OFF_CMAR  = 10'h014;

	localparam logic [2:0] FUNC_REG_RD  = 3'd0;
	localparam logic [2:0] FUNC_REG_WR  = 3'd1;
	localparam logic [2:0] FUNC_PER_REQ = 3'd2;
	localparam logic [2:0] FUNC_RD_RSP  = 3'd3;
	localparam logic [2:0] FUNC_WR_RSP  = 3'd4;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_MEM_RD = 2'd2;
	localparam logic [1:0] KIND_MEM_WR = 2'd3;

	localparam int CCR_EN   = 0;
	localparam int CCR_TCIE = 1;
	localparam int CCR_HTIE = 2;
	localparam int CCR_TEIE = 3;
	localparam int CCR_DIR  = 4;
	localparam int CCR_CIRC = 5;
	localparam int CCR_PINC = 6;
	localparam int CCR_MINC = 7;
	localparam int CCR_M2M  = 14;
	localparam logic [14:0] CCR_PROT = 15'h7ff0;

	typedef enum logic [2:0] {
		SEL_NONE, SEL_ISR, SEL_IFCR, SEL_CCR, SEL_CNDTR, SEL_CPAR, SEL_CMAR
	} reg_sel_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RD   = 3'b010,
		PH_WR   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [14:0] ctl;
		logic [15:0] rem;
		logic [15:0] prog;
		logic [31:0] pbase;
		logic [31:0] mbase;
	} chan_entry_t;

	function automatic logic [1:0] size_code(input logic [1:0] c);
		return (c == 2'd3) ? 2'd2 : c;
	endfunction

	function automatic logic [31:0] width_mask(input logic [1:0] c);
		case (c)
			2'd0: return 32'h0000_00ff;
			2'd1: return 32'h0000_ffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [1:0] side_size(input chan_entry_t e, input logic mem_side);
		return size_code(mem_side ? e.ctl[11:10] : e.ctl[9:8]);
	endfunction

	// Next address on one side: base + item width * items done if the side increments.
	function automatic logic [31:0] side_addr(input chan_entry_t e, input logic mem_side);
		logic [15:0] done;
		logic [31:0] step;
		logic        inc;
		done = e.prog - e.rem;
		step = {16'b0, done} << side_size(e, mem_side);
		inc  = mem_side ? e.ctl[CCR_MINC] : e.ctl[CCR_PINC];
		return (mem_side ? e.mbase : e.pbase) + (inc ? step : 32'b0);
	endfunction

endpackage

// ===== rtl/mdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/multi_channel_dma_controller_core.sv =====
// Top level of the multi-channel DMA controller core.
// Depends on mdc_pkg and mdc_ram.

// One bus event enters per clock while the stage and output registers are not stalled, and each gives
// one result: a transaction is decoded and its channel entry read from the channel RAM as it is
// accepted, then modified and written back in stage 2, and its result then sits in an output
// register, so throughput is one transaction per cycle when the output is free. Back-to-back
// accesses to the same channel are forwarded around the RAM. After reset every channel
// reads as zero until written; no clearing pass is needed.
module multi_channel_dma_controller_core #(
	parameter int CHANNELS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [9:0]  reg_offset,
	input  logic [31:0] write_value,
	input  logic [2:0]  request_channel,
	input  logic [31:0] fetched_data,
	input  logic        bus_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] read_data,
	output logic [31:0] mem_address,
	output logic [1:0]  mem_size,
	output logic [31:0] mem_write_data,
	output logic [6:0]  irq_lines
);
	import mdc_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FW = 4 * CHANNELS;
	localparam int EW = $bits(chan_entry_t);

	// Pipeline stage 1 and forwarding
	logic              valid_s1;
	logic [2:0]        func_s1;
	reg_sel_t          sel_s1;
	logic [CW-1:0]     ch_s1;
	logic              chok_s1;
	logic [31:0]       wval_s1;
	logic [31:0]       fdata_s1;
	logic              berr_s1;
	logic              fwd_s1;
	chan_entry_t       fwd_data_s1;

	// Global state
	logic [FW-1:0]     flags_q, flags_n;
	logic [CHANNELS-1:0] irq_q, irq_n;
	phase_t            phase_q, phase_n;
	logic [CW-1:0]     active_q, active_n;
	logic              burst_q, burst_n;
	logic [(1<<CW)-1:0] ent_vld_q;

	logic              accept, advance;
	reg_sel_t          d_sel;
	logic [CW-1:0]     d_ch, d_regch;
	logic              d_chok, d_hit;

	logic [EW-1:0]     ram_rdata;
	chan_entry_t       e, e_n;
	logic              wr_en;

	logic [1:0]        o_kind, o_size;
	logic [31:0]       o_rdata, o_addr, o_wdata;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Register decode: match the global ISR and IFCR offsets and find the channel whose register window covers the offset.
	always_comb begin
		logic [9:0] lo;
		logic [9:0] diff;
		d_hit   = 1'b0;
		d_regch = '0;
		d_sel   = SEL_NONE;
		lo      = '0;
		diff    = '0;
		if (reg_offset == OFF_ISR) begin
			d_sel = SEL_ISR;
		end else if (reg_offset == OFF_IFCR) begin
			d_sel = SEL_IFCR;
		end
		for (int i = 0; i < CHANNELS; i++) begin
			lo = OFF_CCR + 10'(CHAN_STRIDE * i);
			if (reg_offset >= lo && reg_offset < lo + 10'(CHAN_STRIDE)) begin
				d_hit   = 1'b1;
				d_regch = CW'(i);
				diff    = reg_offset - lo;
				case (diff)
					OFF_CCR - OFF_CCR:   d_sel = SEL_CCR;
					OFF_CNDTR - OFF_CCR: d_sel = SEL_CNDTR;
					OFF_CPAR - OFF_CCR:  d_sel = SEL_CPAR;
					OFF_CMAR - OFF_CCR:  d_sel = SEL_CMAR;
					default:             d_sel = SEL_NONE;
				endcase
			end
		end
	end

	always_comb begin
		case (func)
			FUNC_REG_RD, FUNC_REG_WR: begin
				d_ch   = d_regch;
				d_chok = d_hit && d_sel != SEL_NONE;
			end
			FUNC_PER_REQ: begin
				d_ch   = request_channel[CW-1:0];
				d_chok = int'(request_channel) < CHANNELS;
			end
			FUNC_RD_RSP, FUNC_WR_RSP: begin
				d_ch   = active_n;
				d_chok = 1'b1;
			end
			default: begin
				d_ch   = '0;
				d_chok = 1'b0;
			end
		endcase
	end

	mdc_ram #(
		.WIDTH(EW),
		.DEPTH(CHANNELS)
	) u_chan_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ch_s1),
		.wdata (e_n),
		.re    (accept),
		.raddr (d_ch),
		.rdata (ram_rdata)
	);

	assign wr_en = advance && chok_s1;
	assign e = fwd_s1 ? fwd_data_s1 : (ent_vld_q[ch_s1] ? chan_entry_t'(ram_rdata) : '0);

	// Stage 2: modify the channel entry and the global flags, and form the result.
	always_comb begin
		logic       do_issue;
		logic       do_upd;
		logic       start_req;
		logic       start_burst;
		logic [3:0] add_nib;
		logic [3:0] bc;
		logic [3:0] nib;
		logic [14:0] v;
		logic       dir;
		e_n         = e;
		flags_n     = flags_q;
		irq_n       = irq_q;
		phase_n     = phase_q;
		active_n    = active_q;
		burst_n     = burst_q;
		o_kind      = KIND_NONE;
		o_rdata     = '0;
		o_addr      = '0;
		o_size      = '0;
		o_wdata     = '0;
		do_issue    = 1'b0;
		do_upd      = 1'b0;
		start_req   = 1'b0;
		start_burst = 1'b0;
		add_nib     = '0;
		bc          = '0;
		nib         = '0;
		v           = '0;
		dir         = e.ctl[CCR_DIR];
		if (valid_s1) begin
			case (func_s1)
				FUNC_REG_RD: begin
					o_kind = KIND_REG;
					case (sel_s1)
						SEL_ISR:   o_rdata = 32'(flags_q);
						SEL_CCR:   o_rdata = chok_s1 ? 32'(e.ctl) : '0;
						SEL_CNDTR: o_rdata = chok_s1 ? 32'(e.rem) : '0;
						SEL_CPAR:  o_rdata = chok_s1 ? e.pbase : '0;
						SEL_CMAR:  o_rdata = chok_s1 ? e.mbase : '0;
						default:   o_rdata = '0;
					endcase
				end
				FUNC_REG_WR: begin
					case (sel_s1)
						SEL_IFCR: begin
							for (int i = 0; i < CHANNELS; i++) begin
								bc = wval_s1[4*i +: 4] & flags_q[4*i +: 4];
								if (bc != 4'b0) begin
									nib = bc[0] ? 4'b0 : (flags_q[4*i +: 4] & ~bc);
									flags_n[4*i +: 4] = nib;
									if (nib == 4'b0) begin
										irq_n[i] = 1'b0;
									end
								end
							end
						end
						SEL_CCR: begin
							v = wval_s1[14:0];
							if (e.ctl[CCR_EN] && wval_s1[CCR_EN]) begin
								v = (v & ~CCR_PROT) | (e.ctl & CCR_PROT);
							end
							e_n.ctl = v;
							if (!e.ctl[CCR_EN] && wval_s1[CCR_EN] && v[CCR_M2M]) begin
								start_req   = 1'b1;
								start_burst = 1'b1;
							end
						end
						SEL_CNDTR: begin
							if (!e.ctl[CCR_EN]) begin
								e_n.rem  = wval_s1[15:0];
								e_n.prog = wval_s1[15:0];
							end
						end
						SEL_CPAR: begin
							if (!e.ctl[CCR_EN]) begin
								e_n.pbase = wval_s1;
							end
						end
						SEL_CMAR: begin
							if (!e.ctl[CCR_EN]) begin
								e_n.mbase = wval_s1;
							end
						end
						default: ;
					endcase
				end
				FUNC_PER_REQ: begin
					start_req = chok_s1;
				end
				FUNC_RD_RSP: begin
					if (phase_q == PH_RD) begin
						if (berr_s1) begin
							add_nib[3] = e.ctl[CCR_TEIE];
							phase_n    = PH_IDLE;
							do_upd     = 1'b1;
						end else begin
							phase_n = PH_WR;
							o_kind  = KIND_MEM_WR;
							o_addr  = side_addr(e, !dir);
							o_size  = side_size(e, !dir);
							o_wdata = fdata_s1 & width_mask(side_size(e, dir));
						end
					end
				end
				FUNC_WR_RSP: begin
					if (phase_q == PH_WR) begin
						do_upd = 1'b1;
						if (berr_s1) begin
							add_nib[3] = e.ctl[CCR_TEIE];
							phase_n    = PH_IDLE;
						end else begin
							if (e.rem != 16'b0) begin
								e_n.rem = e.rem - 16'd1;
							end
							add_nib[2] = e.ctl[CCR_HTIE] && e_n.rem == {1'b0, e.prog[15:1]};
							if (e_n.rem == 16'b0) begin
								add_nib[1] = e.ctl[CCR_TCIE];
								if (!e.ctl[CCR_M2M] && e.ctl[CCR_CIRC]) begin
									e_n.rem = e.prog;
								end
								phase_n = PH_IDLE;
							end else if (burst_q && e.ctl[CCR_EN]) begin
								do_issue = 1'b1;
							end else begin
								phase_n = PH_IDLE;
							end
						end
					end
				end
				default: ;
			endcase

			if (start_req && phase_q == PH_IDLE && e_n.ctl[CCR_EN] && e_n.rem != 16'b0) begin
				active_n = ch_s1;
				burst_n  = start_burst;
				do_issue = 1'b1;
			end

			if (do_issue) begin
				phase_n = PH_RD;
				o_kind  = KIND_MEM_RD;
				o_addr  = side_addr(e_n, e_n.ctl[CCR_DIR]);
				o_size  = side_size(e_n, e_n.ctl[CCR_DIR]);
			end

			for (int i = 0; i < CHANNELS; i++) begin
				if (ch_s1 == CW'(i)) begin
					flags_n[4*i +: 4] = flags_n[4*i +: 4] | add_nib;
					if (do_upd && flags_n[4*i +: 4] != 4'b0) begin
						flags_n[4*i] = 1'b1;
						irq_n[i]     = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
			flags_q   <= '0;
			irq_q     <= '0;
			phase_q   <= PH_IDLE;
			active_q  <= '0;
			burst_q   <= 1'b0;
			ent_vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= wr_en && (ch_s1 == d_ch);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				flags_q  <= flags_n;
				irq_q    <= irq_n;
				phase_q  <= phase_n;
				active_q <= active_n;
				burst_q  <= burst_n;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (wr_en) begin
				ent_vld_q[ch_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			sel_s1      <= d_sel;
			ch_s1       <= d_ch;
			chok_s1     <= d_chok;
			wval_s1     <= write_value;
			fdata_s1    <= fetched_data;
			berr_s1     <= bus_error;
			fwd_data_s1 <= e_n;
		end
		if (advance) begin
			kind           <= o_kind;
			read_data      <= o_rdata;
			mem_address    <= o_addr;
			mem_size       <= o_size;
			mem_write_data <= o_wdata;
			irq_lines      <= 7'(irq_n);
		end
	end
endmodule

// ===== rtl/mdc_checker.sv =====
// Port-level checker for the DMA controller core, bound to the top level.
// Depends on mdc_pkg.
module mdc_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [31:0] read_data,
	input logic [31:0] mem_address,
	input logic [1:0]  mem_size,
	input logic [31:0] mem_write_data
);
	import mdc_pkg::*;

	// A stalled result transaction stays valid and keeps its kind and memory address.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(mem_address))
		else $error("result changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NONE |-> read_data == 32'b0 && mem_address == 32'b0)
		else $error("empty result carries data");

	a_rd_nowdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_MEM_RD || kind == KIND_REG) |-> mem_write_data == 32'b0)
		else $error("write data on a non-write result");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mem_size != 2'd3)
		else $error("illegal access size");
endmodule

bind multi_channel_dma_controller_core mdc_assertions u_mdc_checker (.*);
